[rtl/bpm_pkg.sv]
// bpm_pkg: shared widths, register indexes, sequencer states and the
// exponent root table for the barrier path monitor.
// No dependencies.
package bpm_pkg;

  localparam int PRICE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 34;
  localparam int LOG_W     = 29;   // Q5.24 log2
  localparam int LOG_ITERS = 24;
  localparam int CNT_W     = 5;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BARRIER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REBATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_UP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_IN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUT      = 3'd6;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CHECK = 12'b000000000010,
    S_LINIT = 12'b000000000100,
    S_LUPD  = 12'b000000001000,
    S_MD    = 12'b000000010000,
    S_MT    = 12'b000000100000,
    S_MV    = 12'b000001000000,
    S_ME1   = 12'b000010000000,
    S_ME2   = 12'b000100000000,
    S_EXP   = 12'b001000000000,
    S_EXPF  = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  typedef logic [31:0] rtab_t [LOG_ITERS];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bt != 64'd0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // entry j holds 2^(-2^-(j+1)) in Q0.32 by repeated integer square root
  function automatic rtab_t rtab_build();
    rtab_t       t;
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 0; j < LOG_ITERS; j++) begin
      r    = isqrt64(r << 32);
      t[j] = r[31:0];
    end
    return t;
  endfunction

  localparam rtab_t R_TAB = rtab_build();

endpackage

[rtl/bpm_if.sv]
// bpm_if: valid/ready channel interfaces for price words in and payoff
// words out. Depends on bpm_pkg.
interface bpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpm_pkg::PRICE_W-1:0]  price;
  logic [bpm_pkg::PRICE_W-1:0]  uniform_draw;
  logic                         path_start;
  logic                         path_end;
  modport source(output valid, price, uniform_draw, path_start, path_end, input ready);
  modport sink(input valid, price, uniform_draw, path_start, path_end, output ready);
endinterface

interface bpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpm_pkg::PRICE_W-1:0]  payoff;
  logic                         path_hit;
  modport source(output valid, payoff, path_hit, input ready);
  modport sink(input valid, payoff, path_hit, output ready);
endinterface

[rtl/bpm_mul.sv]
// bpm_mul: shared unsigned multiplier with registered product.
// Depends on bpm_pkg.
module bpm_mul (
  input  logic                          clk,
  input  logic [bpm_pkg::MUL_W-1:0]     op_a,
  input  logic [bpm_pkg::MUL_W-1:0]     op_b,
  output logic [2*bpm_pkg::MUL_W-1:0]   prod_r
);
  import bpm_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[rtl/barrier_path_monitor_core.sv]
// barrier_path_monitor_core: top level of the barrier crossing monitor.
// Depends on bpm_pkg, bpm_if and bpm_mul.
//
// One price word is taken per step of a simulated path; the block keeps the
// previous price and a sticky hit flag, and on a path_end word returns one
// payoff word (vanilla payoff, knock-out rebate, or zero for an unhit
// knock-in). Steps that are settled without the bridge test (start word,
// path already hit, a price on or past the barrier, zero-price cases) go
// from the check step straight to the finish step. A bridge-tested step
// runs three Q5.24 log2 evaluations (24 squarings each), five product
// steps and a 24-step exponent, all on the one shared 34x34 multiplier.
// in_ready is high only while the sequencer is idle; a finished payoff
// waits in the output register and the block keeps taking words until a
// second payoff would overwrite it.
module barrier_path_monitor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpm_pkg::PRICE_W-1:0]     cfg_wdata,
  bpm_in_if.sink                          in_ch,
  bpm_out_if.source                       out_ch
);
  import bpm_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOG_ITERS - 1);

  // leading-one normalize in five halving steps; returns {msb index, Q1.31}
  function automatic logic [36:0] norm32(input logic [31:0] x);
    logic [31:0] v;
    logic [4:0]  lz;
    v  = x;
    lz = '0;
    if (v[31:16] == 16'd0) begin v = {v[15:0], 16'd0}; lz[4] = 1'b1; end
    if (v[31:24] == 8'd0)  begin v = {v[23:0], 8'd0};  lz[3] = 1'b1; end
    if (v[31:28] == 4'd0)  begin v = {v[27:0], 4'd0};  lz[2] = 1'b1; end
    if (v[31:30] == 2'd0)  begin v = {v[29:0], 2'd0};  lz[1] = 1'b1; end
    if (v[31] == 1'b0)     begin v = {v[30:0], 1'b0};  lz[0] = 1'b1; end
    return {5'd31 - lz, v};
  endfunction

  // configuration
  logic [31:0] barrier_r, strike_r, rebate_r, scale_r;
  logic        dir_up_r, knock_in_r, put_r;

  // item and path state
  state_t                 state_r, state_nxt;
  logic [31:0]            price_r, price_nxt;
  logic [31:0]            u_r, u_nxt;
  logic                   start_r, start_nxt;
  logic                   end_r, end_nxt;
  logic [31:0]            prev_r, prev_nxt;
  logic                   hit_flag_r, hit_flag_nxt;

  // sequencer datapath
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [1:0]             sel_r, sel_nxt;
  logic [LOG_W-1:0]       res_r, res_nxt;
  logic [LOG_W-1:0]       logs_r [3];
  logic [LOG_W-1:0]       logs_nxt [3];
  logic [MUL_W-1:0]       v_r, v_nxt;
  logic [49:0]            eh_r, eh_nxt;
  logic [23:0]            frac_r, frac_nxt;
  logic [4:0]             k_r, k_nxt;
  logic [32:0]            acc_r, acc_nxt;
  logic                   pend_r, pend_nxt;

  // output word
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_payoff_r, out_payoff_nxt;
  logic                   out_hit_r, out_hit_nxt;

  // shared multiplier
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     prod_r;

  // combinational helpers
  logic [32:0]            sq;
  logic                   lbit;
  logic [31:0]            mnew;
  logic [31:0]            norm_x;
  logic [36:0]            norm_o;
  logic [LOG_W-1:0]       d1, d2;
  logic [50:0]            e_full;
  logic [32:0]            acc_cur;
  logic [32:0]            p_val;
  logic                   bridge_hit;
  logic [31:0]            vanilla, pay;
  logic                   out_load;

  bpm_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.payoff      = out_payoff_r;
  assign out_ch.path_hit    = out_hit_r;

  // configuration writes; index 7 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      barrier_r  <= '0;
      strike_r   <= '0;
      rebate_r   <= '0;
      scale_r    <= '0;
      dir_up_r   <= 1'b0;
      knock_in_r <= 1'b0;
      put_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BARRIER:  barrier_r  <= cfg_wdata;
        REG_STRIKE:   strike_r   <= cfg_wdata;
        REG_REBATE:   rebate_r   <= cfg_wdata;
        REG_SCALE:    scale_r    <= cfg_wdata;
        REG_DIR_UP:   dir_up_r   <= cfg_wdata[0];
        REG_KNOCK_IN: knock_in_r <= cfg_wdata[0];
        REG_PUT:      put_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // log squaring step: m*m in Q2.62 back to Q1.31, top bit is the next digit
  assign sq   = prod_r[63:31];
  assign lbit = sq[32];
  assign mnew = lbit ? sq[32:1] : sq[31:0];

  always_comb begin
    unique case (sel_r)
      2'd0:    norm_x = barrier_r;
      2'd1:    norm_x = prev_r;
      default: norm_x = price_r;
    endcase
  end
  assign norm_o = norm32(norm_x);

  // log differences are taken toward the barrier so they stay non-negative
  assign d1 = dir_up_r ? (logs_r[0] - logs_r[1]) : (logs_r[1] - logs_r[0]);
  assign d2 = dir_up_r ? (logs_r[0] - logs_r[2]) : (logs_r[2] - logs_r[0]);

  // exact (v*scale)>>16 from the two half products
  assign e_full  = {1'b0, eh_r} + 51'(prod_r[49:16]);
  assign acc_cur = pend_r ? prod_r[64:32] : acc_r;
  assign p_val   = acc_cur >> k_r;
  assign bridge_hit = ({1'b0, u_r} < p_val);

  // payoff from the terminal price and the path's flag
  always_comb begin
    if (put_r) vanilla = (strike_r > price_r) ? (strike_r - price_r) : '0;
    else       vanilla = (price_r > strike_r) ? (price_r - strike_r) : '0;
    if (knock_in_r) pay = hit_flag_r ? vanilla : '0;
    else            pay = hit_flag_r ? rebate_r : vanilla;
  end

  assign out_load = (state_r == S_FIN) && end_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    price_nxt      = price_r;
    u_nxt          = u_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    prev_nxt       = prev_r;
    hit_flag_nxt   = hit_flag_r;
    cnt_nxt        = cnt_r;
    sel_nxt        = sel_r;
    res_nxt        = res_r;
    logs_nxt       = logs_r;
    v_nxt          = v_r;
    eh_nxt         = eh_r;
    frac_nxt       = frac_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_payoff_nxt = out_payoff_r;
    out_hit_nxt    = out_hit_r;
    mul_a          = '0;
    mul_b          = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          price_nxt = in_ch.price;
          u_nxt     = in_ch.uniform_draw;
          start_nxt = in_ch.path_start;
          end_nxt   = in_ch.path_end;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_FIN;
        sel_nxt   = 2'd0;
        if (start_r) begin
          hit_flag_nxt = 1'b0;
        end else if (!hit_flag_r) begin
          if (dir_up_r) begin
            if (prev_r >= barrier_r || price_r >= barrier_r) hit_flag_nxt = 1'b1;
            else if (prev_r != 32'd0 && price_r != 32'd0)   state_nxt = S_LINIT;
          end else begin
            if (prev_r <= barrier_r || price_r <= barrier_r) hit_flag_nxt = 1'b1;
            else if (barrier_r != 32'd0)                    state_nxt = S_LINIT;
          end
        end
      end
      S_LINIT: begin
        res_nxt   = LOG_W'(norm_o[36:32]);
        cnt_nxt   = '0;
        mul_a     = MUL_W'(norm_o[31:0]);
        mul_b     = MUL_W'(norm_o[31:0]);
        state_nxt = S_LUPD;
      end
      S_LUPD: begin
        res_nxt = {res_r[LOG_W-2:0], lbit};
        if (cnt_r == CNT_LAST) begin
          logs_nxt[sel_r] = {res_r[LOG_W-2:0], lbit};
          if (sel_r == 2'd2) begin
            state_nxt = S_MD;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_LINIT;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          mul_a   = MUL_W'(mnew);
          mul_b   = MUL_W'(mnew);
        end
      end
      S_MD: begin
        mul_a     = MUL_W'(d1);
        mul_b     = MUL_W'(d2);
        state_nxt = S_MT;
      end
      S_MT: begin
        mul_a     = prod_r[57:24];          // t, Q.24
        mul_b     = MUL_W'(LN2_Q30);
        state_nxt = S_MV;
      end
      S_MV: begin
        v_nxt     = prod_r[63:30];
        mul_a     = prod_r[63:30];
        mul_b     = MUL_W'(scale_r[31:16]);
        state_nxt = S_ME1;
      end
      S_ME1: begin
        eh_nxt    = prod_r[49:0];
        mul_a     = v_r;
        mul_b     = MUL_W'(scale_r[15:0]);
        state_nxt = S_ME2;
      end
      S_ME2: begin
        // integer part of 32 or more: probability is zero, no hit
        if (e_full[50:29] != '0) begin
          state_nxt = S_FIN;
        end else begin
          frac_nxt  = e_full[23:0];
          k_nxt     = e_full[28:24];
          acc_nxt   = 33'h1_0000_0000;
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        acc_nxt  = acc_cur;
        pend_nxt = frac_r[CNT_LAST - cnt_r];
        if (frac_r[CNT_LAST - cnt_r]) begin
          mul_a = MUL_W'(acc_cur);
          mul_b = MUL_W'(R_TAB[cnt_r]);
        end
        if (cnt_r == CNT_LAST) state_nxt = S_EXPF;
        else                   cnt_nxt   = cnt_r + 1'b1;
      end
      S_EXPF: begin
        if (bridge_hit) hit_flag_nxt = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        prev_nxt = price_r;
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_payoff_nxt = pay;
          out_hit_nxt    = hit_flag_r;
          hit_flag_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      hit_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sel_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      hit_flag_r  <= hit_flag_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r      <= price_nxt;
    u_r          <= u_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    res_r        <= res_nxt;
    logs_r       <= logs_nxt;
    v_r          <= v_nxt;
    eh_r         <= eh_nxt;
    frac_r       <= frac_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    out_payoff_r <= out_payoff_nxt;
    out_hit_r    <= out_hit_nxt;
  end

`ifndef SYNTH
  // a payoff word appears only out of the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("payoff word raised outside finish step");

  // an accepted word always goes to the step check next
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_CHECK))
    else $error("accepted word not checked");

  // iteration counter stays inside the root table and digit range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LUPD || state_r == S_EXP) |-> (cnt_r <= CNT_LAST))
    else $error("iteration counter out of range");

  // the path flag is cleared once its payoff word is loaded
  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !hit_flag_r)
    else $error("hit flag kept past path end");
`endif

endmodule
